@@ sv/pftab_pkg.sv @@
// ----------------------------------------------------------------------------
// pftab_pkg
// shared constants for the page frame table allocator
// ----------------------------------------------------------------------------
package pftab_pkg;

  // default configuration
  localparam int DEF_ENTRIES      = 4096;
  localparam int DEF_PAGE_BYTES   = 4096;
  localparam int DEF_ADDRESS_BITS = 52;

  // fixed field widths
  localparam int MODE_W = 3;
  localparam int RB_W   = 52;
  localparam int RUN_W  = 13;
  localparam int STAT_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC1 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOCR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREE1  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FREER  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

@@ sv/pftab_ram.sv @@
// ----------------------------------------------------------------------------
// pftab_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pftab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/page_frame_table_allocator_core.sv @@
// ----------------------------------------------------------------------------
// page_frame_table_allocator_core
// first-fit page frame table: region add, single and run alloc, frees
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | in_mode, in_address, in_region_bytes,
//           |                    | in_run_pages
//  out      | out_valid/out_stall| out_status, out_page_address,
//           |                    | out_entries_used
//
//  one request at a time; a region add appends its pages and then closes, a
//  scan streams one table entry per cycle from the page and free-mark rams,
//  and a run op then sweeps the free marks over run_pages entries; each
//  request also has a setup step and a result hand-off.
//  the table rams need no clearing: entries past entry_count are never read.
//  reset clears the entry count, the sequencer and the result valid flag.
//  a stalled result holds; the next request is taken while it waits.
module page_frame_table_allocator_core
  import pftab_pkg::*;
#(
  parameter int ENTRIES      = DEF_ENTRIES,
  parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [ADDRESS_BITS-1:0] in_address,
  input  logic [RB_W-1:0]         in_region_bytes,
  input  logic [RUN_W-1:0]        in_run_pages,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic [ADDRESS_BITS-1:0] out_page_address,
  output logic [CNT_W-1:0]        out_entries_used
);

  localparam int SH     = $clog2(PAGE_BYTES);
  localparam int PN_W   = ADDRESS_BITS - SH;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LEFT_W = RB_W - SH;
  localparam int CMP_W  = ((CNT_W > RUN_W) ? CNT_W : RUN_W) + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [PN_W-1:0]     addr_pn_r, addr_pn_nxt;
  logic                addr_ok_r, addr_ok_nxt;
  // region add
  logic [PN_W-1:0]     add_pn_r, add_pn_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  // scan stream
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                pv_r, pv_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  // run search
  logic [CNT_W-1:0]    run_len_r, run_len_nxt;
  logic [IDX_W-1:0]    run_start_r, run_start_nxt;
  logic [PN_W-1:0]     run_pn_r, run_pn_nxt;
  logic [PN_W-1:0]     prev_pn_r, prev_pn_nxt;
  // free-mark sweep
  logic [IDX_W-1:0]    sw_idx_r, sw_idx_nxt;
  logic [RUN_W-1:0]    sw_left_r, sw_left_nxt;
  logic                sw_val_r, sw_val_nxt;
  // pending result
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic [PN_W-1:0]     res_pn_r, res_pn_nxt;
  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;
  logic [PN_W-1:0]     out_pn_r, out_pn_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  // ram ports
  logic                pg_we;
  logic [IDX_W-1:0]    pg_waddr;
  logic [PN_W-1:0]     pg_wdata;
  logic [PN_W-1:0]     pg_rdata;
  logic                fm_we;
  logic [IDX_W-1:0]    fm_waddr;
  logic [0:0]          fm_wdata;
  logic [0:0]          fm_rdata;
  logic [IDX_W-1:0]    raddr;

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign raddr    = rd_idx_r[IDX_W-1:0];

  pftab_ram #(.WIDTH(PN_W), .DEPTH(ENTRIES)) u_page_ram (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(raddr), .rdata(pg_rdata)
  );

  pftab_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_mark_ram (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(raddr), .rdata(fm_rdata)
  );

  always_comb begin
    logic [RB_W-1:0]   pg_w;
    logic [RB_W-1:0]   size_adj;
    logic              base_zero;
    logic              lo_nz;
    logic [PN_W-1:0]   base_pn;
    logic              run_bad;
    logic [CNT_W-1:0]  new_len;
    logic              hit;
    logic [CMP_W-1:0]  end_pos;

    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    run_nxt       = run_r;
    addr_pn_nxt   = addr_pn_r;
    addr_ok_nxt   = addr_ok_r;
    add_pn_nxt    = add_pn_r;
    left_nxt      = left_r;
    rd_idx_nxt    = rd_idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    run_pn_nxt    = run_pn_r;
    prev_pn_nxt   = prev_pn_r;
    sw_idx_nxt    = sw_idx_r;
    sw_left_nxt   = sw_left_r;
    sw_val_nxt    = sw_val_r;
    res_stat_nxt  = res_stat_r;
    res_pn_nxt    = res_pn_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_stat_nxt  = out_stat_r;
    out_pn_nxt    = out_pn_r;
    out_cnt_nxt   = out_cnt_r;

    pg_we    = 1'b0;
    pg_waddr = count_r[IDX_W-1:0];
    pg_wdata = add_pn_r;
    fm_we    = 1'b0;
    fm_waddr = count_r[IDX_W-1:0];
    fm_wdata = 1'b1;

    // region setup: base zero drops a page, base aligned up, size in pages
    pg_w      = RB_W'(PAGE_BYTES);
    base_zero = (in_address == '0);
    lo_nz     = (in_address[SH-1:0] != '0);
    base_pn   = in_address[ADDRESS_BITS-1:SH];
    if (base_zero) begin
      size_adj = (in_region_bytes >= pg_w) ? in_region_bytes - pg_w : '0;
    end else begin
      size_adj = in_region_bytes;
    end
    run_bad = (in_run_pages == '0) ||
              (CMP_W'(in_run_pages) > CMP_W'(count_r));

    new_len = '0;
    hit     = 1'b0;
    end_pos = CMP_W'(pidx_r) + CMP_W'(run_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt     = in_mode;
          run_nxt      = in_run_pages;
          addr_pn_nxt  = base_pn;
          addr_ok_nxt  = !lo_nz;
          rd_idx_nxt   = '0;
          run_len_nxt  = '0;
          res_stat_nxt = ST_MISS;
          res_pn_nxt   = '0;
          unique case (in_mode) inside
            MODE_ADD: begin
              add_pn_nxt = base_zero ? PN_W'(1) : base_pn + PN_W'(lo_nz);
              // aligning up past the top of the address space adds nothing
              left_nxt   = (!base_zero && lo_nz && (&base_pn)) ?
                           '0 : size_adj[RB_W-1:SH];
              state_nxt  = S_ADD;
            end
            MODE_ALLOC1, MODE_FREE1: begin
              state_nxt = S_SCAN;
            end
            MODE_ALLOCR, MODE_FREER: begin
              state_nxt = run_bad ? S_DONE : S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ADD: begin
        if (left_r == '0) begin
          res_stat_nxt = ST_OK;
          state_nxt    = S_DONE;
        end else if (count_r >= CNT_W'(ENTRIES)) begin
          res_stat_nxt = ST_FULL;
          state_nxt    = S_DONE;
        end else begin
          pg_we     = 1'b1;
          fm_we     = 1'b1;
          count_nxt = count_r + 1'b1;
          left_nxt  = left_r - 1'b1;
          add_pn_nxt = add_pn_r + 1'b1;
          // last page of the address space ends the region
          if (&add_pn_r) begin
            res_stat_nxt = ST_OK;
            state_nxt    = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // issue the next entry read
        if (rd_idx_r < count_r) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (!pv_r) begin
          state_nxt = S_DONE;
        end
        // look at the entry read last cycle
        if (pv_r) begin
          case (mode_r)
            MODE_ALLOC1: begin
              if (fm_rdata[0]) begin
                fm_we        = 1'b1;
                fm_waddr     = pidx_r;
                fm_wdata     = 1'b0;
                res_stat_nxt = ST_OK;
                res_pn_nxt   = pg_rdata;
                state_nxt    = S_DONE;
              end
            end
            MODE_FREE1: begin
              if (addr_ok_r && pg_rdata == addr_pn_r) begin
                fm_we        = 1'b1;
                fm_waddr     = pidx_r;
                fm_wdata     = 1'b1;
                res_stat_nxt = ST_OK;
                state_nxt    = S_DONE;
              end
            end
            MODE_ALLOCR: begin
              if (fm_rdata[0]) begin
                if (run_len_r != '0 && pg_rdata == prev_pn_r + 1'b1) begin
                  new_len = run_len_r + 1'b1;
                end else begin
                  new_len       = CNT_W'(1);
                  run_start_nxt = pidx_r;
                  run_pn_nxt    = pg_rdata;
                end
                hit = (CMP_W'(new_len) == CMP_W'(run_r));
              end
              run_len_nxt = new_len;
              prev_pn_nxt = pg_rdata;
              if (hit) begin
                sw_idx_nxt   = (new_len == CNT_W'(1)) ? pidx_r : run_start_r;
                res_pn_nxt   = (new_len == CNT_W'(1)) ? pg_rdata : run_pn_r;
                sw_left_nxt  = run_r;
                sw_val_nxt   = 1'b0;
                res_stat_nxt = ST_OK;
                state_nxt    = S_SWEEP;
              end
            end
            default: begin
              // free run: start index must leave room for the whole run
              if (end_pos > CMP_W'(count_r)) begin
                state_nxt = S_DONE;
              end else if (addr_ok_r && pg_rdata == addr_pn_r) begin
                sw_idx_nxt   = pidx_r;
                sw_left_nxt  = run_r;
                sw_val_nxt   = 1'b1;
                res_stat_nxt = ST_OK;
                state_nxt    = S_SWEEP;
              end
            end
          endcase
        end
      end

      S_SWEEP: begin
        fm_we       = 1'b1;
        fm_waddr    = sw_idx_r;
        fm_wdata    = sw_val_r;
        sw_idx_nxt  = sw_idx_r + 1'b1;
        sw_left_nxt = sw_left_r - 1'b1;
        if (sw_left_r == RUN_W'(1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_pn_nxt    = res_pn_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    run_r       <= run_nxt;
    addr_pn_r   <= addr_pn_nxt;
    addr_ok_r   <= addr_ok_nxt;
    add_pn_r    <= add_pn_nxt;
    left_r      <= left_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pidx_r      <= pidx_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    run_pn_r    <= run_pn_nxt;
    prev_pn_r   <= prev_pn_nxt;
    sw_idx_r    <= sw_idx_nxt;
    sw_left_r   <= sw_left_nxt;
    sw_val_r    <= sw_val_nxt;
    res_stat_r  <= res_stat_nxt;
    res_pn_r    <= res_pn_nxt;
    out_stat_r  <= out_stat_nxt;
    out_pn_r    <= out_pn_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_page_address = {out_pn_r, {SH{1'b0}}};
  assign out_entries_used = out_cnt_r;

endmodule

@@ sv/pftab_checker.sv @@
// ----------------------------------------------------------------------------
// pftab_checker
// port-level checks on the page frame table allocator results
// ----------------------------------------------------------------------------
module pftab_checker
  import pftab_pkg::*;
#(
  parameter int ENTRIES      = DEF_ENTRIES,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [STAT_W-1:0]       out_status,
  input logic [ADDRESS_BITS-1:0] out_page_address,
  input logic [CNT_W-1:0]        out_entries_used
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_page_address) && $stable(out_entries_used))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_page_address == '0)
    else $error("failed request returned a page");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entries_used == CNT_W'(ENTRIES))
    else $error("table full reported below capacity");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_used <= CNT_W'(ENTRIES) && out_status <= ST_FULL)
    else $error("result fields out of range");

endmodule

bind page_frame_table_allocator_core pftab_checker #(
  .ENTRIES(ENTRIES),
  .ADDRESS_BITS(ADDRESS_BITS)
) u_pftab_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_status(out_status),
  .out_page_address(out_page_address),
  .out_entries_used(out_entries_used)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed requests against a first-fit page frame table; a
// shadow table predicts status, page address and entry count per request
// ----------------------------------------------------------------------------
module testbench;
  import pftab_pkg::*;

  localparam int  ENTRIES  = DEF_ENTRIES;
  localparam int  PG       = DEF_PAGE_BYTES;
  localparam int  AW       = DEF_ADDRESS_BITS;
  localparam int  CW       = $clog2(ENTRIES + 1);
  localparam longint unsigned AMASK = (64'd1 << AW) - 1;
  localparam int  LIMIT    = 3000000;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [AW-1:0]     page;
    logic [CW-1:0]     used;
  } frame_result_t;

  // shadow copy of the frame table, predicts each request's answer
  class frame_table_tracker;
    logic [AW-1:0] frame_addr [ENTRIES];
    bit            frame_free [ENTRIES];
    int            count;
    int            errors;
    frame_result_t expected_results [$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function logic [STAT_W-1:0] append_region(longint unsigned base,
                                              longint unsigned size);
      longint unsigned rem, up, pages, addr, k;
      if (base == 0) begin
        base = PG;
        size = (size >= PG) ? size - PG : 0;
      end
      rem = base % PG;
      if (rem != 0) begin
        up = base + (PG - rem);
        if (up < base || up > AMASK) return ST_OK;
        base = up;
      end
      if (base > AMASK) return ST_OK;
      pages = size / PG;
      addr  = base;
      for (k = 0; k < pages; k++) begin
        if (count >= ENTRIES) return ST_FULL;
        frame_addr[count] = AW'(addr);
        frame_free[count] = 1'b1;
        count++;
        if (addr > AMASK - PG) break;
        addr += PG;
      end
      return ST_OK;
    endfunction

    function bit run_is_free(int i, int n);
      for (int j = 0; j < n; j++) begin
        if (!frame_free[i+j]) return 0;
        if (j > 0 && frame_addr[i+j] - frame_addr[i+j-1] != PG) return 0;
      end
      return 1;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [AW-1:0] addr,
                               logic [RB_W-1:0] rbytes, logic [RUN_W-1:0] run);
      frame_result_t r;
      int n;
      n        = run;
      r.status = ST_MISS;
      r.page   = '0;
      case (mode)
        MODE_ADD: r.status = append_region(addr, rbytes);
        MODE_ALLOC1: begin
          for (int i = 0; i < count; i++) begin
            if (frame_free[i]) begin
              frame_free[i] = 0;
              r.page   = frame_addr[i];
              r.status = ST_OK;
              break;
            end
          end
        end
        MODE_ALLOCR: begin
          if (n != 0 && n <= count) begin
            for (int i = 0; i + n <= count; i++) begin
              if (run_is_free(i, n)) begin
                for (int j = 0; j < n; j++) frame_free[i+j] = 0;
                r.page   = frame_addr[i];
                r.status = ST_OK;
                break;
              end
            end
          end
        end
        MODE_FREE1: begin
          for (int i = 0; i < count; i++) begin
            if (frame_addr[i] == addr) begin
              frame_free[i] = 1;
              r.status = ST_OK;
              break;
            end
          end
        end
        MODE_FREER: begin
          if (n != 0 && n <= count) begin
            for (int i = 0; i + n <= count; i++) begin
              if (frame_addr[i] == addr) begin
                for (int j = 0; j < n; j++) frame_free[i+j] = 1;
                r.status = ST_OK;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      r.used = CW'(count);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [AW-1:0] page,
                               logic [CW-1:0] used);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d page %h used %0d", status, page, used);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (page !== e.page) begin
        $error("page_address: expected %h, got %h", e.page, page);
        errors++;
      end
      if (used !== e.used) begin
        $error("entries_used: expected %0d, got %0d", e.used, used);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = MODE_ADD;
  logic [AW-1:0]     in_address = '0;
  logic [RB_W-1:0]   in_region_bytes = '0;
  logic [RUN_W-1:0]  in_run_pages = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [AW-1:0]     out_page_address;
  logic [CW-1:0]     out_entries_used;

  frame_table_tracker tracker = new();
  bit quiet = 0;            // no idling on either side while set
  int cycles = 0;
  int stall_left = 0;
  int mode_tally [8];
  int results_seen = 0;

  page_frame_table_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_address(in_address),
    .in_region_bytes(in_region_bytes), .in_run_pages(in_run_pages),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_page_address(out_page_address),
    .out_entries_used(out_entries_used)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("page_frame_table_allocator_core verification failed");
      $finish;
    end
  end

  // result side: check on accept, then draw a stall for the next result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_status, out_page_address, out_entries_used);
      results_seen++;
      stall_left = quiet ? 0 : $urandom_range(0, 4);
      if (stall_left > 0) out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  // one request: optional gap, then hold until taken
  task automatic send_request(logic [MODE_W-1:0] mode, logic [AW-1:0] addr,
                              logic [RB_W-1:0] rbytes, logic [RUN_W-1:0] run);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode         <= mode;
    in_address      <= addr;
    in_region_bytes <= rbytes;
    in_run_pages    <= run;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(mode, addr, rbytes, run);
    mode_tally[mode]++;
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // address of a random existing entry, or a random page if the table is empty
  function automatic logic [AW-1:0] known_page();
    if (tracker.count == 0) return AW'({$urandom, $urandom} & AMASK & ~64'hFFF);
    return tracker.frame_addr[$urandom_range(0, tracker.count - 1)];
  endfunction

  task automatic random_request();
    int pick;
    logic [AW-1:0] addr;
    logic [RB_W-1:0] rbytes;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // small region, aligned or not, low addresses so runs line up
      addr   = AW'({$urandom_range(0, 511), 12'h000});
      if ($urandom_range(0, 3) == 0) addr = addr | AW'($urandom_range(1, 4095));
      if ($urandom_range(0, 9) == 0) addr = '0;
      rbytes = RB_W'($urandom_range(0, 8) * PG + $urandom_range(0, 4095));
      send_request(MODE_ADD, addr, rbytes, '0);
    end else if (pick < 18) begin
      // anywhere in the address space, few pages
      addr   = AW'({$urandom, $urandom} & AMASK);
      rbytes = RB_W'($urandom_range(0, 3) * PG + $urandom_range(0, 4095));
      send_request(MODE_ADD, addr, rbytes, '0);
    end else if (pick < 22) begin
      // near the top with a huge length: pages past the space are skipped
      addr   = AW'(AMASK - $urandom_range(0, 3 * PG));
      rbytes = RB_W'({$urandom, $urandom});
      send_request(MODE_ADD, addr, rbytes, '0);
    end else if (pick < 45) begin
      send_request(MODE_ALLOC1, AW'({$urandom, $urandom}), RB_W'({$urandom, $urandom}),
                   RUN_W'($urandom));
    end else if (pick < 60) begin
      send_request(MODE_ALLOCR, AW'({$urandom, $urandom}), '0,
                   RUN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096)
                                                      : $urandom_range(1, 6)));
    end else if (pick < 78) begin
      addr = ($urandom_range(0, 4) == 0) ? AW'({$urandom, $urandom}) : known_page();
      send_request(MODE_FREE1, addr, RB_W'({$urandom, $urandom}), RUN_W'($urandom));
    end else if (pick < 95) begin
      addr = ($urandom_range(0, 5) == 0) ? AW'({$urandom, $urandom}) : known_page();
      send_request(MODE_FREER, addr, '0,
                   RUN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096)
                                                      : $urandom_range(1, 6)));
    end else begin
      send_request(MODE_W'($urandom_range(5, 7)), AW'({$urandom, $urandom}),
                   RB_W'({$urandom, $urandom}), RUN_W'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: base zero regions, alignment, address space top, runs
    send_request(MODE_ALLOC1, '0, '0, '0);                 // empty table
    send_request(MODE_ADD, '0, 52'h800, '0);               // base zero, under a page
    send_request(MODE_ADD, '0, RB_W'(5 * PG), '0);         // base zero loses a page
    send_request(MODE_ADD, 52'h3_0010, RB_W'(3 * PG + 52'h7FF), '0); // unaligned base
    send_request(MODE_ADD, 52'h9_0000, '0, '0);            // empty region
    send_request(MODE_ADD, AW'(AMASK - 2 * PG + 1), {RB_W{1'b1}}, '0); // runs off the top
    send_request(MODE_ADD, AW'(AMASK), RB_W'(PG), '0);     // aligns past the top
    send_request(MODE_ALLOC1, '0, '0, '0);
    send_request(MODE_ALLOCR, '0, '0, '0);                 // zero run
    send_request(MODE_ALLOCR, '0, '0, 13'd3);
    send_request(MODE_ALLOCR, '0, '0, 13'd4096);           // longer than table
    send_request(MODE_FREE1, 52'h1000, '0, '0);
    send_request(MODE_FREE1, 52'hDEAD_B000, '0, '0);       // not in table
    send_request(MODE_FREER, 52'h1000, '0, '0);            // zero run
    send_request(MODE_FREER, 52'h1000, '0, 13'd2);
    send_request(MODE_FREER, 52'hBEEF_0000, '0, 13'd1);    // not in table
    send_request(MODE_ALLOCR, '0, '0, 13'd4);
    send_request(MODE_FREER, 52'h3_1000, '0, 13'd6);       // by index past run end
    send_request(3'd5, '0, '0, '0);
    send_request(3'd7, AW'(AMASK), {RB_W{1'b1}}, {RUN_W{1'b1}});
    in_valid <= 1'b0;

    // wait for all outstanding answers before random traffic
    drain();

    for (int n = 0; n < 114; n++) begin
      quiet = (n >= 50 && n < 75);
      random_request();
    end
    quiet = 0;

    // fill the table: extra pages are dropped with a full status
    send_request(MODE_ADD, 52'h1_0000_0000, {RB_W{1'b1}}, '0);
    send_request(MODE_ADD, 52'h2000_0000, RB_W'(4 * PG), '0);
    send_request(MODE_ALLOC1, '0, '0, '0);
    send_request(MODE_FREER, tracker.frame_addr[0], '0, 13'd4096);
    send_request(MODE_ALLOCR, '0, '0, 13'd4096);
    send_request(MODE_FREE1, tracker.frame_addr[ENTRIES-1], '0, '0);
    in_valid <= 1'b0;

    drain();
    repeat (20) @(posedge clk);
    $display("requests: add %0d, alloc one %0d, alloc run %0d, free one %0d, free run %0d",
             mode_tally[MODE_ADD], mode_tally[MODE_ALLOC1], mode_tally[MODE_ALLOCR],
             mode_tally[MODE_FREE1], mode_tally[MODE_FREER]);
    $display("%0d results checked, table filled to %0d entries", results_seen,
             tracker.count);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("page_frame_table_allocator_core verification clean");
    end else begin
      $display("page_frame_table_allocator_core verification failed");
    end
    $finish;
  end

endmodule
